/* hw/rtl/interval_overlap_counter_core_defines.svh */
// Assertion macros shared by the interval overlap counter RTL.
`ifndef INTERVAL_OVERLAP_COUNTER_CORE_DEFINES_SVH
`define INTERVAL_OVERLAP_COUNTER_CORE_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define IOC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define IOC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/iocnt_pkg.sv */
// Shared constants, types and the saturating-add helper of the interval overlap counter.
package iocnt_pkg;

  localparam int MAX_POSITIONS = 1024;
  localparam int COUNT_BITS    = 20;
  localparam int TREE_NODES    = 2 * MAX_POSITIONS;
  localparam int NODE_AW       = $clog2(TREE_NODES);
  localparam int IDX_W         = NODE_AW + 1;
  localparam int POS_W         = 11;
  localparam int OUT_W         = 20;

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [NODE_AW-1:0]    node_addr_t;
  typedef logic [IDX_W-1:0]      node_idx_t;
  typedef logic [POS_W-1:0]      pos_t;

  // Lane operation codes.
  typedef logic [3:0] lane_op_t;
  localparam lane_op_t LOP_NOP       = 4'd0;
  localparam lane_op_t LOP_CLEAR     = 4'd1;
  localparam lane_op_t LOP_BUMP_INIT = 4'd2;
  localparam lane_op_t LOP_BUMP_LEAF = 4'd3;
  localparam lane_op_t LOP_BUMP_SIB  = 4'd4;
  localparam lane_op_t LOP_BUMP_PAR  = 4'd5;
  localparam lane_op_t LOP_QRY_INIT  = 4'd6;
  localparam lane_op_t LOP_QRY_LO    = 4'd7;
  localparam lane_op_t LOP_QRY_HI    = 4'd8;
  localparam lane_op_t LOP_QRY_SHIFT = 4'd9;

  typedef struct packed {
    lane_op_t   op;
    pos_t       pos;
    node_addr_t clr_addr;
  } lane_cmd_t;

  typedef struct packed {
    logic at_root;
    logic active;
  } lane_sts_t;

  function automatic count_t sat_add(input count_t a, input count_t b);
    logic [COUNT_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_add = s[COUNT_BITS] ? '1 : s[COUNT_BITS-1:0];
  endfunction

endpackage

/* hw/rtl/iocnt_in_if.sv */
// Input item channel: operation and interval end positions.
interface iocnt_in_if;
  logic                   valid;
  logic                   ready;
  logic                   operation;
  iocnt_pkg::pos_t        left_end;
  iocnt_pkg::pos_t        right_end;

  modport source (output valid, output operation, output left_end, output right_end,
                  input ready);
  modport sink   (input valid, input operation, input left_end, input right_end,
                  output ready);
endinterface

/* hw/rtl/iocnt_out_if.sv */
// Result item channel: overlap count and range error flag.
interface iocnt_out_if;
  logic                         valid;
  logic                         ready;
  logic [iocnt_pkg::OUT_W-1:0]  overlap_count;
  logic                         range_error;

  modport source (output valid, output overlap_count, output range_error, input ready);
  modport sink   (input valid, input overlap_count, input range_error, output ready);
endinterface

/* hw/rtl/interval_overlap_counter_core.sv */
// Top level of the interval overlap counter: two sum-tree lanes and their controller.
//
//   channel  | direction | fields                                 | handshake
//   ---------+-----------+----------------------------------------+----------------
//   in_if    | sink      | operation, left_end, right_end         | valid / ready
//   out_if   | source    | overlap_count, range_error             | valid / ready
//   cfg_     | sink      | cfg_wdata -> position_count            | cfg_we, no wait
//
// After reset the block runs a clearing pass over all 2048 tree nodes, one node of
// each tree per cycle, and in_if.ready stays low until the pass has ended.
// An add item keeps in_if.ready low while it writes the leaf and then does one read
// and one write per tree level on each node memory, up to the root; both trees are
// updated in lockstep.
// A query item walks the tree level by level with a low step, a high step and a
// shift, making up to two reads per level on the single memory read port, and ends
// with a final check and the result load, with ready low throughout.
// A rejected item goes from acceptance straight to the result load.
// Results leave through an output register, so the next item is taken while an
// earlier result still waits on out_if.ready; a query or rejected item only stalls in
// its last cycle while that register still holds a result that has not been taken.

`include "interval_overlap_counter_core_defines.svh"

module interval_overlap_counter_core (
  input  logic              clk,
  input  logic              rst_n,
  iocnt_in_if.sink          in_if,
  iocnt_out_if.source       out_if,
  input  logic              cfg_we,
  input  iocnt_pkg::pos_t   cfg_wdata
);

  iocnt_pkg::lane_cmd_t start_cmd, end_cmd;
  iocnt_pkg::lane_sts_t start_sts, end_sts;
  iocnt_pkg::count_t    start_sum, end_sum;

  logic                        res_free;
  logic                        res_load;
  logic                        res_err;
  logic                        out_valid_r;
  logic [iocnt_pkg::OUT_W-1:0] overlap_r, overlap_nxt;
  logic                        err_r;

  // The controller owns the range check, the position limit and the sequencing.
  iocnt_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_if.valid),
    .in_ready     (in_if.ready),
    .in_operation (in_if.operation),
    .in_left_end  (in_if.left_end),
    .in_right_end (in_if.right_end),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .start_cmd    (start_cmd),
    .end_cmd      (end_cmd),
    .start_sts    (start_sts),
    .end_sts      (end_sts),
    .res_free     (res_free),
    .res_load     (res_load),
    .res_err      (res_err)
  );

  // Tree of interval starts.
  iocnt_lane u_start_lane (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (start_cmd),
    .sts   (start_sts),
    .sum   (start_sum)
  );

  // Tree of interval ends.
  iocnt_lane u_end_lane (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (end_cmd),
    .sts   (end_sts),
    .sum   (end_sum)
  );

  // The output register is free when empty or when its item leaves this cycle.
  assign res_free = !out_valid_r || out_if.ready;

  // Overlaps are starts up to the right end minus ends before the left end. When
  // saturation pushes the end count above the start count the result is zero.
  always_comb begin
    if (res_err || (start_sum <= end_sum)) begin
      overlap_nxt = '0;
    end else begin
      overlap_nxt = iocnt_pkg::OUT_W'(start_sum - end_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      overlap_r <= overlap_nxt;
      err_r     <= res_err;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.overlap_count = overlap_r;
  assign out_if.range_error   = err_r;

  // A flagged result never carries a count.
  `IOC_ASSERT_SAME(a_err_zero_count, out_valid_r && err_r, overlap_r == '0, "flagged result has a count")

endmodule

/* hw/rtl/iocnt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module iocnt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/iocnt_lane.sv */
// One sum tree lane: node memory plus the update and prefix-sum datapath.
`include "interval_overlap_counter_core_defines.svh"

module iocnt_lane (
  input  logic                 clk,
  input  logic                 rst_n,
  input  iocnt_pkg::lane_cmd_t cmd,
  output iocnt_pkg::lane_sts_t sts,
  output iocnt_pkg::count_t    sum
);

  iocnt_pkg::node_addr_t idx_r, idx_nxt;
  iocnt_pkg::count_t     cur_r, cur_nxt;
  iocnt_pkg::node_idx_t  lo_r, lo_nxt;
  iocnt_pkg::node_idx_t  hi_r, hi_nxt;
  iocnt_pkg::count_t     acc_r, acc_nxt;
  logic                  pend_r, pend_nxt;

  logic                  we, re;
  iocnt_pkg::node_addr_t waddr, raddr;
  iocnt_pkg::count_t     wdata, rdata;
  iocnt_pkg::node_idx_t  leaf;
  iocnt_pkg::count_t     par_sum;
  logic                  active;

  iocnt_ram #(
    .WIDTH (iocnt_pkg::COUNT_BITS),
    .DEPTH (iocnt_pkg::TREE_NODES)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign leaf    = iocnt_pkg::node_idx_t'(iocnt_pkg::MAX_POSITIONS)
                 + iocnt_pkg::node_idx_t'(cmd.pos) - iocnt_pkg::node_idx_t'(1);
  assign par_sum = iocnt_pkg::sat_add(cur_r, rdata);
  assign active  = lo_r < hi_r;

  always_comb begin
    we       = 1'b0;
    re       = 1'b0;
    waddr    = idx_r;
    raddr    = idx_r;
    wdata    = '0;
    idx_nxt  = idx_r;
    cur_nxt  = cur_r;
    lo_nxt   = lo_r;
    hi_nxt   = hi_r;
    pend_nxt = 1'b0;
    // Read data requested in the previous cycle is folded in here.
    acc_nxt  = pend_r ? iocnt_pkg::sat_add(acc_r, rdata) : acc_r;
    case (cmd.op)
      iocnt_pkg::LOP_CLEAR: begin
        we    = 1'b1;
        waddr = cmd.clr_addr;
        wdata = '0;
      end
      iocnt_pkg::LOP_BUMP_INIT: begin
        idx_nxt = leaf[iocnt_pkg::NODE_AW-1:0];
        re      = 1'b1;
        raddr   = leaf[iocnt_pkg::NODE_AW-1:0];
      end
      iocnt_pkg::LOP_BUMP_LEAF: begin
        we      = 1'b1;
        waddr   = idx_r;
        wdata   = iocnt_pkg::sat_add(rdata, iocnt_pkg::count_t'(1));
        cur_nxt = wdata;
      end
      iocnt_pkg::LOP_BUMP_SIB: begin
        re    = 1'b1;
        raddr = idx_r ^ iocnt_pkg::node_addr_t'(1);
      end
      iocnt_pkg::LOP_BUMP_PAR: begin
        we      = 1'b1;
        waddr   = idx_r >> 1;
        wdata   = par_sum;
        cur_nxt = par_sum;
        idx_nxt = idx_r >> 1;
      end
      iocnt_pkg::LOP_QRY_INIT: begin
        lo_nxt  = iocnt_pkg::node_idx_t'(iocnt_pkg::MAX_POSITIONS);
        hi_nxt  = iocnt_pkg::node_idx_t'(iocnt_pkg::MAX_POSITIONS)
                + iocnt_pkg::node_idx_t'(cmd.pos);
        acc_nxt = '0;
      end
      iocnt_pkg::LOP_QRY_LO: begin
        if (active && lo_r[0]) begin
          re       = 1'b1;
          raddr    = lo_r[iocnt_pkg::NODE_AW-1:0];
          lo_nxt   = lo_r + iocnt_pkg::node_idx_t'(1);
          pend_nxt = 1'b1;
        end
      end
      iocnt_pkg::LOP_QRY_HI: begin
        if (active && hi_r[0]) begin
          hi_nxt   = hi_r - iocnt_pkg::node_idx_t'(1);
          re       = 1'b1;
          raddr    = hi_nxt[iocnt_pkg::NODE_AW-1:0];
          pend_nxt = 1'b1;
        end
      end
      iocnt_pkg::LOP_QRY_SHIFT: begin
        lo_nxt = lo_r >> 1;
        hi_nxt = hi_r >> 1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    cur_r <= cur_nxt;
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    acc_r <= acc_nxt;
  end

  assign sts.at_root = idx_r == iocnt_pkg::node_addr_t'(1);
  assign sts.active  = active;
  assign sum         = acc_r;

  // A prefix walk never lets its lower bound pass the upper one.
  `IOC_ASSERT_NEXT(a_lo_not_past_hi, cmd.op == iocnt_pkg::LOP_QRY_SHIFT, lo_r <= hi_r, "query bounds crossed")

endmodule

/* hw/rtl/iocnt_ctrl.sv */
// Controller: clearing pass, range check and sequencing of both tree lanes.
`include "interval_overlap_counter_core_defines.svh"

module iocnt_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_operation,
  input  iocnt_pkg::pos_t      in_left_end,
  input  iocnt_pkg::pos_t      in_right_end,
  input  logic                 cfg_we,
  input  iocnt_pkg::pos_t      cfg_wdata,
  output iocnt_pkg::lane_cmd_t start_cmd,
  output iocnt_pkg::lane_cmd_t end_cmd,
  input  iocnt_pkg::lane_sts_t start_sts,
  input  iocnt_pkg::lane_sts_t end_sts,
  input  logic                 res_free,
  output logic                 res_load,
  output logic                 res_err
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_BLEAF = 4'd2;
  localparam logic [3:0] S_BSIB  = 4'd3;
  localparam logic [3:0] S_BPAR  = 4'd4;
  localparam logic [3:0] S_QLO   = 4'd5;
  localparam logic [3:0] S_QHI   = 4'd6;
  localparam logic [3:0] S_QSH   = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0]            state_r, state_nxt;
  iocnt_pkg::node_addr_t clr_r, clr_nxt;
  iocnt_pkg::pos_t       pc_r, pc_nxt;
  logic                  err_r, err_nxt;
  logic                  in_fire;
  logic                  bad;

  assign in_ready = state_r == S_IDLE;
  assign in_fire  = in_valid && in_ready;

  assign bad = (in_left_end == '0) || (in_right_end == '0)
            || (in_left_end > pc_r) || (in_right_end > pc_r)
            || (in_left_end > in_right_end)
            || (32'(in_right_end) > 32'(iocnt_pkg::MAX_POSITIONS));

  always_comb begin
    state_nxt          = state_r;
    clr_nxt            = clr_r;
    err_nxt            = err_r;
    pc_nxt             = cfg_we ? cfg_wdata : pc_r;
    res_load           = 1'b0;
    start_cmd.op       = iocnt_pkg::LOP_NOP;
    start_cmd.pos      = in_left_end;
    start_cmd.clr_addr = clr_r;
    end_cmd.op         = iocnt_pkg::LOP_NOP;
    end_cmd.pos        = in_right_end;
    end_cmd.clr_addr   = clr_r;
    case (state_r)
      S_CLEAR: begin
        start_cmd.op = iocnt_pkg::LOP_CLEAR;
        end_cmd.op   = iocnt_pkg::LOP_CLEAR;
        clr_nxt      = clr_r + iocnt_pkg::node_addr_t'(1);
        if (clr_r == '1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          err_nxt = bad;
          if (bad) begin
            state_nxt = S_DONE;
          end else if (!in_operation) begin
            start_cmd.op = iocnt_pkg::LOP_BUMP_INIT;
            end_cmd.op   = iocnt_pkg::LOP_BUMP_INIT;
            state_nxt    = S_BLEAF;
          end else begin
            // Starts up to the right end, ends up to just before the left end.
            start_cmd.op  = iocnt_pkg::LOP_QRY_INIT;
            start_cmd.pos = in_right_end;
            end_cmd.op    = iocnt_pkg::LOP_QRY_INIT;
            end_cmd.pos   = in_left_end - iocnt_pkg::pos_t'(1);
            state_nxt     = S_QLO;
          end
        end
      end
      S_BLEAF: begin
        start_cmd.op = iocnt_pkg::LOP_BUMP_LEAF;
        end_cmd.op   = iocnt_pkg::LOP_BUMP_LEAF;
        state_nxt    = S_BSIB;
      end
      S_BSIB: begin
        if (start_sts.at_root) begin
          state_nxt = S_IDLE;
        end else begin
          start_cmd.op = iocnt_pkg::LOP_BUMP_SIB;
          end_cmd.op   = iocnt_pkg::LOP_BUMP_SIB;
          state_nxt    = S_BPAR;
        end
      end
      S_BPAR: begin
        start_cmd.op = iocnt_pkg::LOP_BUMP_PAR;
        end_cmd.op   = iocnt_pkg::LOP_BUMP_PAR;
        state_nxt    = S_BSIB;
      end
      S_QLO: begin
        if (!start_sts.active && !end_sts.active) begin
          state_nxt = S_DONE;
        end else begin
          start_cmd.op = iocnt_pkg::LOP_QRY_LO;
          end_cmd.op   = iocnt_pkg::LOP_QRY_LO;
          state_nxt    = S_QHI;
        end
      end
      S_QHI: begin
        start_cmd.op = iocnt_pkg::LOP_QRY_HI;
        end_cmd.op   = iocnt_pkg::LOP_QRY_HI;
        state_nxt    = S_QSH;
      end
      S_QSH: begin
        start_cmd.op = iocnt_pkg::LOP_QRY_SHIFT;
        end_cmd.op   = iocnt_pkg::LOP_QRY_SHIFT;
        state_nxt    = S_QLO;
      end
      S_DONE: begin
        if (res_free) begin
          res_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      pc_r    <= iocnt_pkg::pos_t'(1024);
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      pc_r    <= pc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    err_r <= err_nxt;
  end

  assign res_err = err_r;

  // A rejected item goes straight to result delivery.
  `IOC_ASSERT_NEXT(a_bad_to_done, in_fire && bad, state_r == S_DONE, "bad item not flagged")
  // The clearing pass ends after the last node address.
  `IOC_ASSERT_NEXT(a_clear_ends, (state_r == S_CLEAR) && (clr_r == '1), state_r == S_IDLE, "clear did not end")

endmodule

/* tb/iocnt_tb_pkg.sv */
// Operation codes shared by the interval overlap counter testbench modules.
`timescale 1ns / 1ps

package iocnt_tb_pkg;

  typedef enum logic {
    OP_ADD   = 1'b0,
    OP_QUERY = 1'b1
  } item_op_e;

endpackage

/* tb/overlap_result_monitor.sv */
// Monitor that predicts overlap results from accepted items and compares them with the block.
`timescale 1ns / 1ps

module overlap_result_monitor
  import iocnt_pkg::*;
  import iocnt_tb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  iocnt_in_if         in_mon,
  iocnt_out_if        out_mon,
  input  logic        cfg_we,
  input  pos_t        cfg_wdata,
  output int          mismatch_total,
  output int          results_owed
);

  localparam int START_TREE = 0;
  localparam int END_TREE   = 1;

  typedef struct packed {
    logic [OUT_W-1:0] overlap_count;
    logic             range_error;
  } overlap_result_t;

  // Bottom-up sum trees; the leaf of position p sits at MAX_POSITIONS + p - 1.
  count_t          node_sums [2][TREE_NODES];
  pos_t            position_limit;
  overlap_result_t predicted_results [$];
  overlap_result_t oldest;
  int              failures;

  function automatic count_t capped_add(input count_t a, input count_t b);
    logic [COUNT_BITS:0] wide;
    wide = {1'b0, a} + {1'b0, b};
    return wide[COUNT_BITS] ? '1 : wide[COUNT_BITS-1:0];
  endfunction

  function automatic void bump_position(input int tree, input int pos);
    int idx;
    idx = MAX_POSITIONS + pos - 1;
    node_sums[tree][idx] = capped_add(node_sums[tree][idx], count_t'(1));
    idx = idx >> 1;
    while (idx >= 1) begin
      node_sums[tree][idx] = capped_add(node_sums[tree][2*idx], node_sums[tree][2*idx+1]);
      idx = idx >> 1;
    end
  endfunction

  // Saturating sum over positions 1..upto.
  function automatic count_t prefix_sum(input int tree, input int upto);
    int     lo;
    int     hi;
    count_t total;
    lo    = MAX_POSITIONS;
    hi    = MAX_POSITIONS + upto;
    total = '0;
    while (lo < hi) begin
      if (lo[0]) begin
        total = capped_add(total, node_sums[tree][lo]);
        lo++;
      end
      if (hi[0]) begin
        hi--;
        total = capped_add(total, node_sums[tree][hi]);
      end
      lo = lo >> 1;
      hi = hi >> 1;
    end
    return total;
  endfunction

  function automatic void predict_item(input logic op, input pos_t left, input pos_t right);
    int              limit;
    count_t          starts;
    count_t          ends;
    overlap_result_t res;
    limit = (position_limit > MAX_POSITIONS) ? MAX_POSITIONS : int'(position_limit);
    if (left < 1 || right < 1 || left > limit || right > limit || left > right) begin
      res.overlap_count = '0;
      res.range_error   = 1'b1;
      predicted_results.push_back(res);
    end else if (op == OP_ADD) begin
      bump_position(START_TREE, int'(left));
      bump_position(END_TREE, int'(right));
    end else begin
      starts            = prefix_sum(START_TREE, int'(right));
      ends              = prefix_sum(END_TREE, int'(left) - 1);
      res.overlap_count = (starts > ends) ? OUT_W'(starts - ends) : '0;
      res.range_error   = 1'b0;
      predicted_results.push_back(res);
    end
  endfunction

  initial begin
    failures = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int t = 0; t < 2; t++)
        for (int n = 0; n < TREE_NODES; n++)
          node_sums[t][n] = '0;
      position_limit = pos_t'(MAX_POSITIONS);
      predicted_results.delete();
    end else begin
      if (cfg_we)
        position_limit = cfg_wdata;
      // A result and an item can meet at one edge; the result always belongs to
      // an earlier item, so it is checked first.
      if (out_mon.valid && out_mon.ready) begin
        if (predicted_results.size() == 0) begin
          $error("unexpected result: overlap_count %0d range_error %0b",
                 out_mon.overlap_count, out_mon.range_error);
          failures++;
        end else begin
          oldest = predicted_results.pop_front();
          if (out_mon.overlap_count !== oldest.overlap_count) begin
            $error("overlap_count: expected %0d, actual %0d",
                   oldest.overlap_count, out_mon.overlap_count);
            failures++;
          end
          if (out_mon.range_error !== oldest.range_error) begin
            $error("range_error: expected %0b, actual %0b",
                   oldest.range_error, out_mon.range_error);
            failures++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        predict_item(in_mon.operation, in_mon.left_end, in_mon.right_end);
    end
    mismatch_total <= failures;
    results_owed   <= predicted_results.size();
  end

endmodule

/* tb/interval_overlap_counter_core_test.sv */
// Top of the interval overlap counter testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module interval_overlap_counter_core_test;
  import iocnt_pkg::*;
  import iocnt_tb_pkg::*;

  // The slack covers an add or the longest query running out inside the block.
  localparam int LATENCY_SLACK  = 40;
  // Longest silent stretch in a correct run is the clearing pass after
  // reset; the limit sits well above it and above any stall plus gap plus item.
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int PHASE_ITEMS    = 225;

  logic clk;
  logic rst_n;
  logic cfg_we;
  pos_t cfg_wdata;
  int   mismatch_total;
  int   results_owed;
  int   idle_cycles;
  int   active_limit;
  bit   calm_source;
  bit   calm_sink;
  int   stall_left;

  iocnt_in_if  in_bus ();
  iocnt_out_if out_bus ();

  interval_overlap_counter_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_bus),
    .out_if    (out_bus),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  overlap_result_monitor i_result_monitor (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_bus),
    .out_mon        (out_bus),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .mismatch_total (mismatch_total),
    .results_owed   (results_owed)
  );

  always #2 clk = ~clk;

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int random_gap();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 60)
      return 0;
    else if (sel < 92)
      return $urandom_range(1, 3);
    else
      return $urandom_range(8, 40);
  endfunction

  // The result side stalls at random. A calm stretch keeps ready high so the
  // block also runs at full rate for a while; the mode flips now and then.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if ($urandom_range(0, 299) == 0)
        calm_sink = !calm_sink;
      if (stall_left > 0) begin
        out_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        out_bus.ready <= 1'b1;
        if (!calm_sink && $urandom_range(0, 99) < 35)
          stall_left = random_gap() + 1;
      end
    end
  end

  // Watchdog: counts cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Presents one item and returns at the edge where it is accepted. Valid stays
  // high when the next item follows without a gap, so it is never lowered and
  // raised in the same step.
  task automatic send_item(input item_op_e op, input pos_t left, input pos_t right);
    int gap;
    gap = calm_source ? 0 : random_gap();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.operation <= op;
    in_bus.left_end  <= left;
    in_bus.right_end <= right;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  // Drops valid and waits until every predicted result has come back, then lets
  // an add that produces no result run out inside the block.
  task automatic settle_idle();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (LATENCY_SLACK) @(posedge clk);
  endtask

  // Writes position_count; only called while the block is idle.
  task automatic configure(input pos_t value);
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    active_limit = (value > MAX_POSITIONS) ? MAX_POSITIONS : int'(value);
  endtask

  // Mostly well-formed intervals inside the active range, short ones often so
  // that overlaps pile up; the rest are out-of-range, reversed or raw noise.
  task automatic send_random_item();
    int       sel;
    int       lo;
    int       hi;
    int       tmp;
    item_op_e op;
    op  = ($urandom_range(0, 99) < 55) ? OP_ADD : OP_QUERY;
    sel = $urandom_range(0, 99);
    if (active_limit == 0 || sel >= 96) begin
      lo = $urandom_range(0, 2047);
      hi = $urandom_range(0, 2047);
    end else if (sel >= 92) begin
      // One end just outside the range, on either side.
      lo = $urandom_range(1, active_limit);
      hi = $urandom_range(0, 1) ? active_limit + 1 : 0;
      if ($urandom_range(0, 1)) begin
        tmp = lo;
        lo  = hi;
        hi  = tmp;
      end
    end else begin
      lo = $urandom_range(1, active_limit);
      if ($urandom_range(0, 1))
        hi = (lo + 7 > active_limit) ? $urandom_range(lo, active_limit)
                                     : lo + $urandom_range(0, 7);
      else
        hi = $urandom_range(lo, active_limit);
      // Reversed pairs, only when the two ends differ.
      if (sel >= 88 && lo != hi) begin
        tmp = lo;
        lo  = hi;
        hi  = tmp;
      end
    end
    send_item(op, pos_t'(lo), pos_t'(hi));
  endtask

  initial begin
    pos_t phase_limit [6];

    clk              = 1'b0;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    in_bus.valid     = 1'b0;
    in_bus.operation = OP_ADD;
    in_bus.left_end  = '0;
    in_bus.right_end = '0;
    calm_source      = 1'b0;
    active_limit     = MAX_POSITIONS;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the full range. The first item waits out the clearing
    // pass that follows reset.
    configure(pos_t'(MAX_POSITIONS));
    send_item(OP_ADD, 11'd1, 11'd1);
    send_item(OP_ADD, 11'd1024, 11'd1024);
    send_item(OP_ADD, 11'd1, 11'd1024);
    send_item(OP_ADD, 11'd5, 11'd9);
    send_item(OP_ADD, 11'd5, 11'd9);
    send_item(OP_QUERY, 11'd1, 11'd1);
    send_item(OP_QUERY, 11'd1024, 11'd1024);
    send_item(OP_QUERY, 11'd1, 11'd1024);
    send_item(OP_QUERY, 11'd6, 11'd8);
    send_item(OP_QUERY, 11'd10, 11'd20);
    // Bad positions: zero ends, reversed range, past the range, all ones.
    send_item(OP_ADD, 11'd0, 11'd5);
    send_item(OP_ADD, 11'd3, 11'd0);
    send_item(OP_QUERY, 11'd7, 11'd6);
    send_item(OP_QUERY, 11'd1025, 11'd1025);
    send_item(OP_ADD, 11'd2047, 11'd2047);
    send_item(OP_QUERY, 11'd1, 11'd2047);

    // A count of zero turns every item into a bad one.
    settle_idle();
    configure(11'd0);
    send_item(OP_ADD, 11'd1, 11'd1);
    send_item(OP_QUERY, 11'd1, 11'd1);

    // Smallest useful range: only position one can be addressed.
    settle_idle();
    configure(11'd1);
    send_item(OP_ADD, 11'd1, 11'd1);
    send_item(OP_QUERY, 11'd1, 11'd1);
    send_item(OP_QUERY, 11'd1, 11'd2);

    // A count above the tree size behaves as the tree size.
    settle_idle();
    configure(11'd2047);
    send_item(OP_ADD, 11'd1024, 11'd1024);
    send_item(OP_QUERY, 11'd1, 11'd1024);
    send_item(OP_ADD, 11'd1025, 11'd1025);

    // Random phases, each under its own range setting. Counts stored under one
    // setting stay in the trees for the next.
    phase_limit[0] = 11'd1024;
    phase_limit[1] = 11'd16;
    phase_limit[2] = pos_t'($urandom_range(100, 1023));
    phase_limit[3] = 11'd2047;
    phase_limit[4] = 11'd2;
    phase_limit[5] = 11'd1024;
    for (int ph = 0; ph < 6; ph++) begin
      settle_idle();
      configure(phase_limit[ph]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 99) == 0)
          calm_source = !calm_source;
        // Once in the run the sender holds off until every result is back.
        if (ph == 2 && n == PHASE_ITEMS / 2) begin
          in_bus.valid <= 1'b0;
          @(posedge clk);
          while (results_owed != 0) @(posedge clk);
        end
        send_random_item();
      end
    end

    // Wind down: no item in flight, then room for a late stray result.
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (LATENCY_SLACK) @(posedge clk);

    if (mismatch_total == 0 && results_owed == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
